@@ design/f2i_pkg.sv @@
// f2i_pkg: shared types, constants and target-code names for the float to integer converter.
// No dependencies.
`timescale 1ns / 1ps
package f2i_pkg;

  localparam int unsigned FuncW = 3;
  localparam int unsigned FloatW = 32;
  localparam int unsigned IntW = 64;

  typedef enum logic [FuncW-1:0] {
    FN_S8  = 3'd0,
    FN_U8  = 3'd1,
    FN_S16 = 3'd2,
    FN_U16 = 3'd3,
    FN_S32 = 3'd4,
    FN_U32 = 3'd5,
    FN_S64 = 3'd6,
    FN_U64 = 3'd7
  } func_t;

  // Decoded operand, stage 1 to stage 2.
  typedef struct packed {
    logic            nan;
    logic            neg;
    logic            big;
    logic            sgn;
    logic [1:0]      wsel;   // 0:8 1:16 2:32 3:64
    logic [IntW-1:0] mag;
  } dec_t;

  // Range check, stage 2 to stage 3.
  typedef struct packed {
    logic            nan;
    logic            neg;
    logic            sgn;
    logic            sat;
    logic [1:0]      wsel;
    logic [IntW-1:0] mag;
  } chk_t;

endpackage

@@ design/float_to_int_saturating_convert_top.sv @@
// float_to_int_saturating_convert_top: pipelined float32 to integer saturating converter.
// Depends on f2i_pkg, f2i_decode, f2i_check, f2i_select.
`timescale 1ns / 1ps
// Usage:
//  Input channel: in_valid/in_stall with func (target type) and value_bits
//  (IEEE single). Output channel: out_valid/out_stall with result,
//  saturated and was_nan.
//  An item is taken when valid is high and stall is low.
//  Pipeline: decode/shift -> range check -> result select, with one
//  register after each: dec_q, chk_q, then the output registers.
//  Throughput: one item per cycle while out_stall is low, each stage holds one item.
//  Stall: a stage advances when the one after it is empty or moving, so
//  bubbles are squeezed out; a full pipe under out_stall holds all items
//  and raises in_stall combinationally from the output stall.
//  Reset (rst, sync, active high) clears all stage valid bits; data
//  registers are not reset.
//  NaN gives zero with was_nan; out-of-range values clamp with saturated.
module float_to_int_saturating_convert_top import f2i_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FuncW-1:0]  func,
  input  logic [FloatW-1:0] value_bits,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IntW-1:0]   result,
  output logic              saturated,
  output logic              was_nan
);
  dec_t dec_c, dec_q;
  chk_t chk_c, chk_q;
  logic [IntW-1:0] res_c;
  logic sat_c, nan_c;
  logic v1, v2;
  logic en3, en2, en1;

  f2i_decode u_dec (.func(func), .value_bits(value_bits), .dec(dec_c));
  f2i_check  u_chk (.dec(dec_q), .chk(chk_c));
  f2i_select u_sel (.chk(chk_q), .result(res_c), .saturated(sat_c), .was_nan(nan_c));

  assign en3 = !out_valid || !out_stall;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) out_valid <= v2;
    end
    if (en1 && in_valid) dec_q <= dec_c;
    if (en2 && v1) chk_q <= chk_c;
    if (en3 && v2) begin
      result    <= res_c;
      saturated <= sat_c;
      was_nan   <= nan_c;
    end
  end

  // NaN results are zero and never saturated.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && was_nan |-> result == '0 && !saturated)
    else $error("nan result not clean");
  // A held output must be untouched while stalled.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result))
    else $error("output changed under stall");
  // Input is stalled only when every stage holds an item.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v1 && v2 && out_valid)
    else $error("stall with free stage");
endmodule

@@ design/f2i_decode.sv @@
// f2i_decode: unpacks the float and shifts the significand into a truncated 64-bit magnitude.
// Depends on f2i_pkg.
`timescale 1ns / 1ps
module f2i_decode import f2i_pkg::*; (
  input  logic [FuncW-1:0]  func,
  input  logic [FloatW-1:0] value_bits,
  output dec_t              dec
);
  logic [7:0]  ex;
  logic [22:0] man;
  logic [7:0]  e;
  logic [IntW-1:0] sig;

  always_comb begin
    ex  = value_bits[30:23];
    man = value_bits[22:0];
    e   = ex - 8'd127;
    sig = {{(IntW-24){1'b0}}, 1'b1, man};
    dec.nan  = (ex == 8'hff) && (man != '0);
    dec.neg  = value_bits[31];
    dec.sgn  = ~func[0];
    dec.wsel = func[2:1];
    dec.big  = 1'b0;
    dec.mag  = '0;
    if (ex == 8'hff) begin
      dec.big = 1'b1;
    end else if (ex >= 8'd127) begin
      if (e >= 8'd64) begin
        dec.big = 1'b1;
      end else if (e >= 8'd23) begin
        dec.mag = sig << (e[5:0] - 6'd23);
      end else begin
        dec.mag = sig >> (6'd23 - e[5:0]);
      end
    end
  end
endmodule

@@ design/f2i_check.sv @@
// f2i_check: compares the magnitude against the target range and flags saturation.
// Depends on f2i_pkg.
`timescale 1ns / 1ps
module f2i_check import f2i_pkg::*; (
  input  dec_t dec,
  output chk_t chk
);
  logic [IntW-1:0] hi_bits;   // magnitude bits at or above w-1
  logic [IntW-1:0] lim;       // 2^(w-1)
  logic            over_s_pos;
  logic            over_s_neg;
  logic            over_u;

  always_comb begin
    case (dec.wsel)
      2'd0: begin
        hi_bits = dec.mag & ~64'h7f;
        lim     = 64'h80;
      end
      2'd1: begin
        hi_bits = dec.mag & ~64'h7fff;
        lim     = 64'h8000;
      end
      2'd2: begin
        hi_bits = dec.mag & ~64'h7fff_ffff;
        lim     = 64'h8000_0000;
      end
      default: begin
        hi_bits = dec.mag & ~64'h7fff_ffff_ffff_ffff;
        lim     = 64'h8000_0000_0000_0000;
      end
    endcase
    over_s_pos = hi_bits != '0;
    // Negative bound: magnitude may equal exactly 2^(w-1).
    over_s_neg = over_s_pos && (dec.mag != lim);
    case (dec.wsel)
      2'd0:    over_u = (dec.mag & ~64'hff) != '0;
      2'd1:    over_u = (dec.mag & ~64'hffff) != '0;
      2'd2:    over_u = (dec.mag & ~64'hffff_ffff) != '0;
      default: over_u = 1'b0;
    endcase
    chk.nan  = dec.nan;
    chk.neg  = dec.neg;
    chk.sgn  = dec.sgn;
    chk.wsel = dec.wsel;
    chk.mag  = dec.mag;
    if (dec.nan) begin
      chk.sat = 1'b0;
    end else if (dec.sgn) begin
      chk.sat = dec.big || (dec.neg ? over_s_neg : over_s_pos);
    end else begin
      chk.sat = dec.big || (dec.neg ? (dec.mag != '0) : over_u);
    end
  end
endmodule

@@ design/f2i_select.sv @@
// f2i_select: builds the final 64-bit result from the range-check outcome.
// Depends on f2i_pkg.
`timescale 1ns / 1ps
module f2i_select import f2i_pkg::*; (
  input  chk_t            chk,
  output logic [IntW-1:0] result,
  output logic            saturated,
  output logic            was_nan
);
  logic [IntW-1:0] lim;   // 2^(w-1)
  logic [IntW-1:0] maxu;

  always_comb begin
    case (chk.wsel)
      2'd0:    begin lim = 64'h80;   maxu = 64'hff; end
      2'd1:    begin lim = 64'h8000; maxu = 64'hffff; end
      2'd2:    begin lim = 64'h8000_0000; maxu = 64'hffff_ffff; end
      default: begin lim = 64'h8000_0000_0000_0000; maxu = 64'hffff_ffff_ffff_ffff; end
    endcase
    was_nan   = chk.nan;
    saturated = chk.sat;
    if (chk.nan) begin
      result = '0;
    end else if (chk.sgn) begin
      if (chk.neg) result = chk.sat ? (64'd0 - lim) : (64'd0 - chk.mag);
      else         result = chk.sat ? (lim - 64'd1) : chk.mag;
    end else begin
      if (chk.neg) result = '0;
      else         result = chk.sat ? maxu : chk.mag;
    end
  end
endmodule

@@ sim/float_to_int_saturating_convert_top_test.sv @@
// Testbench for float_to_int_saturating_convert_top: float32 to integer saturating conversion.
// Depends on f2i_pkg and the converter RTL; self-contained stimulus and checking.
`timescale 1ns / 1ps

// Holds expected conversions in arrival order and compares results against them.
class conv_scoreboard;
  typedef struct {
    logic [63:0] result;
    logic        saturated;
    logic        was_nan;
  } conv_exp_t;

  conv_exp_t pending[$];
  int unsigned errors;
  int unsigned checked;

  // Truncating, saturating conversion of one float bit pattern.
  function automatic conv_exp_t convert(f2i_pkg::func_t fn, logic [31:0] bits);
    conv_exp_t   e;
    logic        neg;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [63:0] mag;
    logic [63:0] sig;
    logic [63:0] lim;
    logic [63:0] maxu;
    logic        big;
    logic        is_signed;
    int unsigned w;
    int unsigned sh;
    neg = bits[31];
    ex = bits[30:23];
    man = bits[22:0];
    mag = '0;
    big = 1'b0;
    w = 8 << (fn >> 1);
    is_signed = (fn[0] == 1'b0);
    e.result = '0;
    e.saturated = 1'b0;
    e.was_nan = 1'b0;
    if (ex == 8'hff && man != 0) begin
      e.was_nan = 1'b1;
      return e;
    end
    if (ex == 8'hff) begin
      big = 1'b1;
    end else if (ex >= 8'd127) begin
      sh = ex - 127;
      sig = {40'd0, 1'b1, man};
      if (sh >= 64) big = 1'b1;
      else if (sh >= 23) mag = sig << (sh - 23);
      else mag = sig >> (23 - sh);
    end
    if (is_signed) begin
      lim = 64'd1 << (w - 1);
      if (!neg) begin
        if (big || mag > lim - 1) begin
          e.saturated = 1'b1;
          e.result = lim - 1;
        end else e.result = mag;
      end else begin
        if (big || mag > lim) begin
          e.saturated = 1'b1;
          e.result = -lim;
        end else e.result = -mag;
      end
    end else begin
      maxu = (w >= 64) ? '1 : ((64'd1 << w) - 1);
      if (neg) begin
        e.saturated = big || (mag != 0);
      end else if (big || mag > maxu) begin
        e.saturated = 1'b1;
        e.result = maxu;
      end else e.result = mag;
    end
    return e;
  endfunction

  function void note_input(f2i_pkg::func_t fn, logic [31:0] bits);
    pending.push_back(convert(fn, bits));
  endfunction

  function void check_result(logic [63:0] res, logic sat, logic nan);
    conv_exp_t e;
    if (pending.size() == 0) begin
      $error("result with nothing expected: result=%h saturated=%b was_nan=%b", res, sat, nan);
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    if (res !== e.result) begin
      $error("result: expected %h actual %h", e.result, res);
      errors++;
    end
    if (sat !== e.saturated) begin
      $error("saturated: expected %b actual %b", e.saturated, sat);
      errors++;
    end
    if (nan !== e.was_nan) begin
      $error("was_nan: expected %b actual %b", e.was_nan, nan);
      errors++;
    end
  endfunction
endclass

module float_to_int_saturating_convert_top_test;
  import f2i_pkg::*;

  localparam int unsigned LATENCY = 3;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam longint unsigned CYCLE_LIMIT = 200000;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [FuncW-1:0]  func;
  logic [FloatW-1:0] value_bits;
  logic              out_valid;
  logic              out_stall;
  logic [IntW-1:0]   result;
  logic              saturated;
  logic              was_nan;

  conv_scoreboard    board;
  longint unsigned   cycles;
  // Long receiver hold-off: the driver raises it, the stall process counts it out.
  logic              hold_req;
  int unsigned       sent;

  float_to_int_saturating_convert_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .value_bits(value_bits),
    .out_valid(out_valid), .out_stall(out_stall),
    .result(result), .saturated(saturated), .was_nan(was_nan)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter doubles as the timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: check every accepted item.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(result, saturated, was_nan);
  end

  // Receiver stall pattern: runs of free flow, light and heavy stalling, plus one
  // long hold-off so the pipe fills and pushes back on the input.
  initial begin : stall_gen
    int unsigned mode;
    int unsigned run;
    int unsigned i;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        for (i = 0; i < 60; i++) @(posedge clk);
        hold_req = 1'b0;
      end
      mode = $urandom_range(0, 3);
      run = $urandom_range(1, 30);
      for (i = 0; i < run; i++) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Offer one item and hold it until accepted; valid stays high across items.
  task automatic send_item(input func_t fn, input logic [31:0] bits);
    in_valid <= 1'b1;
    func <= fn;
    value_bits <= bits;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(fn, bits);
    sent++;
  endtask

  task automatic idle_cycles(input int unsigned n);
    in_valid <= 1'b0;
    func <= 3'($urandom());
    value_bits <= $urandom();
    repeat (n) @(posedge clk);
  endtask

  // Random float: biased toward exponents near the integer bounds.
  function automatic logic [31:0] pick_float();
    logic [31:0] b;
    int unsigned k;
    b = $urandom();
    k = $urandom_range(0, 9);
    case (k)
      0, 1, 2, 3: b[30:23] = 8'(127 + $urandom_range(0, 64));
      4: b[30:23] = 8'(127 + ($urandom_range(0, 3) == 0 ? 63 : (8 << $urandom_range(0, 3)) - 1
                               + $urandom_range(0, 1)));
      5: b[30:23] = 8'($urandom_range(0, 127));
      6: b[30:0] = {8'hff, ($urandom_range(0, 1) ? 23'd0 : b[22:0])};
      7: b[22:0] = ($urandom_range(0, 1) ? 23'd0 : 23'h7fffff);
      default: ;
    endcase
    return b;
  endfunction

  task automatic wait_drained();
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin : main
    logic [31:0] edges[$];
    int unsigned f;
    int unsigned j;
    int unsigned burst;
    bit          hold_sent;
    bit          drain_done;
    board = new();
    cycles = 0;
    sent = 0;
    hold_req = 1'b0;
    hold_sent = 1'b0;
    drain_done = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    func <= '0;
    value_bits <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zeros, below one, NaN, infinities, bounds, fraction past a bound,
    // 2^31 and 2^63 exactly, negative fraction to unsigned.
    edges = '{32'h0000_0000, 32'h8000_0000, 32'h3f00_0000, 32'hbf00_0000,
              32'h7fc0_0000, 32'hffff_ffff, 32'h7f80_0000, 32'hff80_0000,
              32'h42ff_0000, 32'h4300_0000, 32'hc300_0000, 32'hc301_0000,
              32'h4f00_0000, 32'hcf00_0000, 32'h5f00_0000, 32'hdf00_0000,
              32'h5f80_0000, 32'h7f7f_ffff, 32'h0000_0001, 32'h437f_8000,
              32'h477f_ff00, 32'hc2ff_0000};
    for (j = 0; j < edges.size(); j++) send_item(func_t'(j % 8), edges[j]);
    for (f = 0; f < 8; f++) send_item(func_t'(f), 32'h7f80_0000);
    idle_cycles(1);
    wait_drained();

    // Random part in bursts with gaps; one long receiver hold-off and one
    // full drain partway through.
    j = 0;
    while (j < RANDOM_ITEMS) begin
      if (j >= 400 && !hold_sent) begin
        hold_req = 1'b1;
        hold_sent = 1'b1;
      end
      if (j >= 900 && !drain_done) begin
        idle_cycles(1);
        wait_drained();
        drain_done = 1'b1;
      end
      burst = $urandom_range(1, 40);
      while (burst > 0 && j < RANDOM_ITEMS) begin
        send_item(func_t'($urandom_range(0, 7)), pick_float());
        j++;
        burst--;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 8));
    end
    idle_cycles(1);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);

    $display("converted %0d items over all eight target types, incl. NaN, infinities,", sent);
    $display("bound edges and a long output hold-off; %0d results checked", board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
design/f2i_pkg.sv
design/f2i_decode.sv
design/f2i_check.sv
design/f2i_select.sv
design/float_to_int_saturating_convert_top.sv
sim/float_to_int_saturating_convert_top_test.sv
